>>> hdl/pipc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pipc_pkg;

   // Default width of the encoder position.
   localparam int POSITION_BITS_DEF = 16;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port widths.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_PERIOD  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETPOINT_MAX   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_BOUND   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTEGRAL_LIMIT = 3'd5;

   // Register values after reset.
   localparam logic [15:0] GAIN_P_RESET         = 16'd1638;
   localparam logic [15:0] GAIN_I_RESET         = 16'd2048;
   localparam logic [15:0] SAMPLE_PERIOD_RESET  = 16'd655;
   localparam logic [7:0]  SETPOINT_MAX_RESET   = 8'd200;
   localparam logic [15:0] OUTPUT_BOUND_RESET   = 16'd131;
   localparam logic [6:0]  INTEGRAL_LIMIT_RESET = 7'd50;

   // Controller settings as seen by the datapath.
   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] sample_period;
      logic [7:0]  setpoint_max;
      logic [15:0] output_bound;
      logic [6:0]  integral_limit;
   } cfg_type;

   // Sequencer states of the back part.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DT,
      ST_MUL_P,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DECIDE,
      ST_MUL_ACC,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> hdl/pipc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pipc_front #(
   parameter int POSITION_BITS = pipc_pkg::POSITION_BITS_DEF
) (
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_setpoint,
   input  wire logic [POSITION_BITS-1:0] req_position,
   input  wire logic [7:0]               setpoint_max,
   input  wire logic                     q_full,
   output logic                          q_push,
   output logic [POSITION_BITS:0]        q_err
);

   localparam int EW = POSITION_BITS + 1;

   logic [7:0] sp_clamped;

   // Hold the sender off while the queue has no room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Clamp the setpoint and form the position error.
   assign sp_clamped = (req_setpoint > setpoint_max) ? setpoint_max : req_setpoint;
   assign q_err      = {{(EW-8){1'b0}}, sp_clamped} - {1'b0, req_position};

endmodule

`default_nettype wire

>>> hdl/pipc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pipc_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = pipc_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/pipc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pipc_back #(
   parameter int POSITION_BITS = pipc_pkg::POSITION_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pipc_pkg::cfg_type     cfg,
   input  wire logic                  q_valid,
   input  wire logic [POSITION_BITS:0] q_err,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [31:0]         rsp_drive,
   output logic                       rsp_integral_taken
);

   // Error, trial integral and control sum widths.
   localparam int EW  = POSITION_BITS + 1;
   localparam int TW  = EW + 17;
   localparam int LOW = 21;
   localparam int MW  = (EW > 24) ? EW : 24;
   localparam int UW  = (EW + 35 > 53) ? EW + 35 : 53;
   localparam int SW  = UW - 20;

   pipc_pkg::state_type state_ff, state_in;

   logic signed [EW-1:0]    err_ff;
   logic signed [EW+15:0]   m_dt_ff;
   logic signed [EW+15:0]   p_ff;
   logic signed [TW-1:0]    trial_ff;
   logic signed [LOW+16:0]  plo_ff;
   logic signed [TW-6:0]    phi_ff;
   logic signed [UW-1:0]    ut_ff;
   logic signed [23:0]      acc_ff, acc_in;
   logic                    take_ff, take_in;
   logic signed [39:0]      pacc_ff;
   logic signed [31:0]      drive_ff, drive_in;
   logic                    taken_out_ff;
   logic                    rsp_valid_ff;

   logic signed [MW-1:0]    mul_a;
   logic [15:0]             mul_b;
   logic signed [MW+16:0]   mul_p;
   logic                    out_load;

   logic signed [UW-1:0]    bound_w;
   logic                    err_neg, err_pos;
   logic signed [TW-1:0]    acc_sel, lim_w;
   logic signed [UW-1:0]    u_w;
   logic signed [SW-1:0]    u_shift;

   // Shared multiplier: signed operand times unsigned 16-bit coefficient.
   assign mul_p = mul_a * $signed({1'b0, mul_b});

   // Next state of the sequencer.
   always_comb begin
      case (state_ff)
         pipc_pkg::ST_IDLE:    state_in = q_valid ? pipc_pkg::ST_MUL_DT : pipc_pkg::ST_IDLE;
         pipc_pkg::ST_MUL_DT:  state_in = pipc_pkg::ST_MUL_P;
         pipc_pkg::ST_MUL_P:   state_in = pipc_pkg::ST_MUL_LO;
         pipc_pkg::ST_MUL_LO:  state_in = pipc_pkg::ST_MUL_HI;
         pipc_pkg::ST_MUL_HI:  state_in = pipc_pkg::ST_SUM;
         pipc_pkg::ST_SUM:     state_in = pipc_pkg::ST_DECIDE;
         pipc_pkg::ST_DECIDE:  state_in = pipc_pkg::ST_MUL_ACC;
         pipc_pkg::ST_MUL_ACC: state_in = pipc_pkg::ST_OUT;
         pipc_pkg::ST_OUT:     state_in = out_load ? pipc_pkg::ST_IDLE : pipc_pkg::ST_OUT;
         default:              state_in = pipc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: multiplier operands, queue pop and result load.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         pipc_pkg::ST_IDLE: begin
            q_pop = q_valid;
         end
         pipc_pkg::ST_MUL_DT: begin
            mul_a = MW'(err_ff);
            mul_b = cfg.sample_period;
         end
         pipc_pkg::ST_MUL_P: begin
            mul_a = MW'(err_ff);
            mul_b = cfg.gain_p;
         end
         pipc_pkg::ST_MUL_LO: begin
            mul_a = MW'($signed({1'b0, trial_ff[LOW-1:0]}));
            mul_b = cfg.gain_i;
         end
         pipc_pkg::ST_MUL_HI: begin
            mul_a = MW'($signed(trial_ff[TW-1:LOW]));
            mul_b = cfg.gain_i;
         end
         pipc_pkg::ST_MUL_ACC: begin
            mul_a = MW'(acc_ff);
            mul_b = cfg.gain_i;
         end
         pipc_pkg::ST_OUT: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Anti-windup decision and integral clamp.
   always_comb begin
      bound_w = UW'($signed({1'b0, cfg.output_bound, 28'd0}));
      err_neg = err_ff[EW-1];
      err_pos = !err_ff[EW-1] && (err_ff != '0);
      take_in = ((ut_ff < bound_w) && (ut_ff > -bound_w)) ||
                ((ut_ff >= bound_w) && err_neg) ||
                ((ut_ff <= -bound_w) && err_pos);
      acc_sel = take_in ? trial_ff : TW'(acc_ff);
      lim_w   = TW'($signed({1'b0, cfg.integral_limit, 16'd0}));
      if (acc_sel > lim_w) begin
         acc_in = lim_w[23:0];
      end else if (acc_sel < -lim_w) begin
         acc_in = 24'(-lim_w);
      end else begin
         acc_in = acc_sel[23:0];
      end
   end

   // Final sum, floor scaling to 1/256 units and 32-bit saturation.
   always_comb begin
      u_w     = (UW'(p_ff) <<< 16) + UW'(pacc_ff);
      u_shift = u_w[UW-1:20];
      if (!u_shift[SW-1] && (|u_shift[SW-2:31])) begin
         drive_in = 32'sh7FFF_FFFF;
      end else if (u_shift[SW-1] && !(&u_shift[SW-2:31])) begin
         drive_in = 32'sh8000_0000;
      end else begin
         drive_in = u_shift[31:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pipc_pkg::ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pipc_pkg::ST_DECIDE) begin
            acc_ff <= acc_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers, each loaded in a set step of the sequencer.
   always_ff @(posedge clock) begin
      case (state_ff)
         pipc_pkg::ST_IDLE: begin
            err_ff <= q_err;
         end
         pipc_pkg::ST_MUL_DT: begin
            m_dt_ff <= mul_p[EW+15:0];
         end
         pipc_pkg::ST_MUL_P: begin
            p_ff     <= mul_p[EW+15:0];
            trial_ff <= TW'(acc_ff) + TW'(m_dt_ff);
         end
         pipc_pkg::ST_MUL_LO: begin
            plo_ff <= mul_p[LOW+16:0];
         end
         pipc_pkg::ST_MUL_HI: begin
            phi_ff <= mul_p[TW-6:0];
         end
         pipc_pkg::ST_SUM: begin
            ut_ff <= (UW'(p_ff) <<< 16) + (UW'(phi_ff) <<< LOW) + UW'(plo_ff);
         end
         pipc_pkg::ST_DECIDE: begin
            take_ff <= take_in;
         end
         pipc_pkg::ST_MUL_ACC: begin
            pacc_ff <= mul_p[39:0];
         end
         pipc_pkg::ST_OUT: begin
            if (out_load) begin
               drive_ff     <= drive_in;
               taken_out_ff <= take_ff;
            end
         end
         default: begin
            err_ff <= err_ff;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive          = drive_ff;
   assign rsp_integral_taken = taken_out_ff;

endmodule

`default_nettype wire

>>> hdl/pi_position_controller_antiwindup.sv
`timescale 1ns / 1ps
`default_nettype none

// PI position controller with conditional-integration anti-windup.
// The req channel carries one sample word (setpoint byte and encoder
// position); the rsp channel returns one word per sample with the drive
// value (1/256 units, saturated to 32 bits) and the integral-taken flag.
// The csr channel writes the gains, sample period, setpoint clamp, output
// bound and integral limit; csr_ready is always high.
// The front part clamps the setpoint, forms the error and places it in a
// two-entry queue. The back part runs a nine-step sequencer around one
// shared 24x17 multiplier and works on one sample at a time, taking the
// next one from the queue once the last response has been loaded.
// A stalled response stays in its output register; the back part keeps
// working on the next sample and waits at its last step until the output
// register frees, and req_stall rises once the queue is full.
// Reset returns the settings registers to their default values and clears the
// stored integral; there is no clearing pass.
module pi_position_controller_antiwindup #(
   parameter int POSITION_BITS = pipc_pkg::POSITION_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_setpoint,
   input  wire logic [POSITION_BITS-1:0]             req_position,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [31:0]                        rsp_drive,
   output logic                                      rsp_integral_taken,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pipc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [pipc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   pipc_pkg::cfg_type        cfg_ff;
   logic                     q_full;
   logic                     q_push;
   logic [POSITION_BITS:0]   q_err_in;
   logic                     q_valid;
   logic                     q_pop;
   logic [POSITION_BITS:0]   q_err_out;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= pipc_pkg::GAIN_P_RESET;
         cfg_ff.gain_i         <= pipc_pkg::GAIN_I_RESET;
         cfg_ff.sample_period  <= pipc_pkg::SAMPLE_PERIOD_RESET;
         cfg_ff.setpoint_max   <= pipc_pkg::SETPOINT_MAX_RESET;
         cfg_ff.output_bound   <= pipc_pkg::OUTPUT_BOUND_RESET;
         cfg_ff.integral_limit <= pipc_pkg::INTEGRAL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pipc_pkg::CSR_GAIN_P:         cfg_ff.gain_p         <= csr_data;
            pipc_pkg::CSR_GAIN_I:         cfg_ff.gain_i         <= csr_data;
            pipc_pkg::CSR_SAMPLE_PERIOD:  cfg_ff.sample_period  <= csr_data;
            pipc_pkg::CSR_SETPOINT_MAX:   cfg_ff.setpoint_max   <= csr_data[7:0];
            pipc_pkg::CSR_OUTPUT_BOUND:   cfg_ff.output_bound   <= csr_data;
            pipc_pkg::CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_data[6:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Front part: setpoint clamp and error.
   pipc_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_setpoint (req_setpoint),
      .req_position (req_position),
      .setpoint_max (cfg_ff.setpoint_max),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_err        (q_err_in)
   );

   // Queue between the two parts.
   pipc_queue #(
      .WIDTH (POSITION_BITS + 1),
      .DEPTH (pipc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_err_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_err_out)
   );

   // Back part: integral update and drive computation.
   pipc_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .q_err              (q_err_out),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .rsp_integral_taken (rsp_integral_taken)
   );

endmodule

`default_nettype wire

>>> bench/pipc_checker.sv
`timescale 1ns / 1ps

// Watches the sample, drive and register channels of the PI controller.
// Keeps its own copy of the settings and of the stored integral, predicts
// the drive word for every accepted sample word and compares each accepted
// drive word with the oldest prediction.
module pipc_checker #(
   parameter int POSITION_BITS = pipc_pkg::POSITION_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [7:0]                          req_setpoint,
   input  wire logic [POSITION_BITS-1:0]            req_position,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic signed [31:0]                  rsp_drive,
   input  wire logic                                rsp_integral_taken,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [pipc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [pipc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int unsigned                              fail_count,
   output int unsigned                              pending_count
);

   // One predicted drive word.
   typedef struct packed {
      logic signed [31:0] drive;
      logic               taken;
   } drive_word_type;

   localparam pipc_pkg::cfg_type DEFAULT_CFG = '{
      gain_p:         pipc_pkg::GAIN_P_RESET,
      gain_i:         pipc_pkg::GAIN_I_RESET,
      sample_period:  pipc_pkg::SAMPLE_PERIOD_RESET,
      setpoint_max:   pipc_pkg::SETPOINT_MAX_RESET,
      output_bound:   pipc_pkg::OUTPUT_BOUND_RESET,
      integral_limit: pipc_pkg::INTEGRAL_LIMIT_RESET
   };

   pipc_pkg::cfg_type  settings = DEFAULT_CFG;
   logic signed [23:0] integ_q16 = '0;
   drive_word_type     drive_q[$];
   drive_word_type     want;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Advances the controller by one sample: decides whether the trial
   // integral is taken, clamps the stored integral and forms the drive.
   function automatic drive_word_type pi_update(input logic [7:0] sp_raw,
                                                input logic [POSITION_BITS-1:0] pos_raw);
      longint sp, err, trial, p28, u_trial, bound, lim, acc, u, drv;
      logic take;
      drive_word_type r;
      sp = longint'(sp_raw);
      if (sp > longint'(settings.setpoint_max)) begin
         sp = longint'(settings.setpoint_max);
      end
      err     = sp - longint'(pos_raw);
      trial   = longint'(integ_q16) + err * longint'(settings.sample_period);
      p28     = longint'(settings.gain_p) * err * 65536;
      u_trial = p28 + longint'(settings.gain_i) * trial;
      bound   = longint'(settings.output_bound) * (longint'(1) << 28);
      // Inside the band, or pushing back out of a bound.
      take = (u_trial < bound && u_trial > -bound) ||
             (u_trial >= bound && err < 0) ||
             (u_trial <= -bound && err > 0);
      // The clamp applies whether or not the trial was taken.
      acc = take ? trial : longint'(integ_q16);
      lim = longint'(settings.integral_limit) * 65536;
      if (acc > lim) begin
         acc = lim;
      end else if (acc < -lim) begin
         acc = -lim;
      end
      integ_q16 = acc[23:0];
      u   = p28 + longint'(settings.gain_i) * longint'(integ_q16);
      drv = u >>> 20;
      if (drv > 64'sd2147483647) begin
         drv = 64'sd2147483647;
      end else if (drv < -64'sd2147483648) begin
         drv = -64'sd2147483648;
      end
      r.drive = drv[31:0];
      r.taken = take;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings  = DEFAULT_CFG;
         integ_q16 = '0;
         drive_q.delete();
      end else begin
         // Compare an accepted drive word with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               $error("drive word with no sample pending: drive %0d, taken %0b",
                      rsp_drive, rsp_integral_taken);
               fail_count++;
            end else begin
               want = drive_q.pop_front();
               if (rsp_drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", want.drive, rsp_drive);
                  fail_count++;
               end
               if (rsp_integral_taken !== want.taken) begin
                  $error("integral_taken: expected %0b, got %0b",
                         want.taken, rsp_integral_taken);
                  fail_count++;
               end
            end
         end

         // Track register writes; unmapped indexes leave the settings alone.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pipc_pkg::CSR_GAIN_P:         settings.gain_p         = csr_data;
               pipc_pkg::CSR_GAIN_I:         settings.gain_i         = csr_data;
               pipc_pkg::CSR_SAMPLE_PERIOD:  settings.sample_period  = csr_data;
               pipc_pkg::CSR_SETPOINT_MAX:   settings.setpoint_max   = csr_data[7:0];
               pipc_pkg::CSR_OUTPUT_BOUND:   settings.output_bound   = csr_data;
               pipc_pkg::CSR_INTEGRAL_LIMIT: settings.integral_limit = csr_data[6:0];
               default: begin
               end
            endcase
         end

         // Predict the drive word for an accepted sample word.
         if (req_valid && !req_stall) begin
            drive_q.push_back(pi_update(req_setpoint, req_position));
         end
      end
      pending_count = drive_q.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

// Drives sample words and register writes into the PI controller, with
// random gaps on the sample side and random stalls on the drive side.
module tb_top;

   localparam int          POS_BITS    = pipc_pkg::POSITION_BITS_DEF;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          SEG_ITEMS   = 170;

   // Indexes with no register behind them.
   localparam logic [pipc_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [pipc_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam pipc_pkg::cfg_type DEFAULT_CFG = '{
      gain_p:         pipc_pkg::GAIN_P_RESET,
      gain_i:         pipc_pkg::GAIN_I_RESET,
      sample_period:  pipc_pkg::SAMPLE_PERIOD_RESET,
      setpoint_max:   pipc_pkg::SETPOINT_MAX_RESET,
      output_bound:   pipc_pkg::OUTPUT_BOUND_RESET,
      integral_limit: pipc_pkg::INTEGRAL_LIMIT_RESET
   };
   localparam pipc_pkg::cfg_type MAX_CFG = '{
      gain_p: 16'hFFFF, gain_i: 16'hFFFF, sample_period: 16'hFFFF,
      setpoint_max: 8'hFF, output_bound: 16'hFFFF, integral_limit: 7'h7F
   };
   localparam pipc_pkg::cfg_type ZERO_CFG = '0;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [7:0]                          req_setpoint;
   logic [POS_BITS-1:0]                 req_position;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [31:0]                  rsp_drive;
   logic                                rsp_integral_taken;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [pipc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [pipc_pkg::CSR_DATA_BITS-1:0]  csr_data;

   int unsigned       fail_count;
   int unsigned       pending_count;
   int unsigned       cycle_count = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;
   pipc_pkg::cfg_type run_cfg = DEFAULT_CFG;

   always #5 clock = ~clock;

   pi_position_controller_antiwindup u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_setpoint       (req_setpoint),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .rsp_integral_taken (rsp_integral_taken),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   pipc_checker #(
      .POSITION_BITS (POS_BITS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_setpoint       (req_setpoint),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .rsp_integral_taken (rsp_integral_taken),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   // Random back-pressure on the drive side.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** pi_position_controller_antiwindup: FAILED **");
      $finish;
   end

   // Offers one sample word after a random gap and waits until it is taken.
   task automatic send_word(input logic [7:0] sp, input logic [POS_BITS-1:0] pos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_setpoint <= sp;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Holds off new samples until every drive word has come back.
   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic csr_write(input logic [pipc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [pipc_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Writes every register, with junk in the unused upper bits, plus one
   // write to an unmapped index that must change nothing.
   task automatic load_settings(input pipc_pkg::cfg_type c);
      run_cfg = c;
      csr_write(pipc_pkg::CSR_GAIN_P, c.gain_p);
      csr_write(pipc_pkg::CSR_GAIN_I, c.gain_i);
      csr_write(pipc_pkg::CSR_SAMPLE_PERIOD, c.sample_period);
      csr_write(pipc_pkg::CSR_SETPOINT_MAX, {8'($urandom), c.setpoint_max});
      csr_write(pipc_pkg::CSR_OUTPUT_BOUND, c.output_bound);
      csr_write(pipc_pkg::CSR_INTEGRAL_LIMIT, {9'($urandom), c.integral_limit});
      csr_write(($urandom_range(0, 1) != 0) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                16'($urandom));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly moderate settings so the integral works inside the band, now
   // and then full-range values.
   function automatic pipc_pkg::cfg_type random_cfg();
      pipc_pkg::cfg_type c;
      c.gain_p         = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191));
      c.gain_i         = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191));
      c.sample_period  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      c.setpoint_max   = 8'($urandom);
      c.output_bound   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      c.integral_limit = 7'($urandom);
      return c;
   endfunction

   // Most positions sit near the effective setpoint so the loop stays in
   // the band; the rest are far away or anywhere in the position range.
   task automatic send_random;
      logic [7:0] sp;
      int         eff;
      int         pos;
      int unsigned pick;
      sp   = 8'($urandom);
      eff  = (sp > run_cfg.setpoint_max) ? int'(run_cfg.setpoint_max) : int'(sp);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         pos = eff + int'($urandom_range(0, 40)) - 20;
         if (pos < 0) begin
            pos = 0;
         end
      end else if (pick < 85) begin
         pos = int'($urandom_range(0, 1023));
      end else begin
         pos = int'($urandom_range(0, (1 << POS_BITS) - 1));
      end
      send_word(sp, POS_BITS'(pos));
   endtask

   initial begin
      pipc_pkg::cfg_type c;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_setpoint = '0;
      req_position = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 24;
      recv_idle_pct = 71;

      // Field extremes and setpoint clamping under the reset settings.
      send_word(8'd0, '0);
      send_word(8'd255, '0);
      send_word(8'd200, '0);
      send_word(8'd201, '0);
      send_word(8'd0, '1);
      send_word(8'd255, '1);
      send_word(8'h80, POS_BITS'(16'h8000));
      send_word(8'h7F, POS_BITS'(16'h7FFF));

      // Wind the integral up, then push back toward the setpoint.
      repeat (4) send_word(8'd200, '0);
      repeat (3) send_word(8'd0, POS_BITS'(120));

      // A lowered limit clamps the stored integral on the very next sample.
      drain();
      c = DEFAULT_CFG;
      c.integral_limit = 7'd3;
      load_settings(c);
      send_word(8'd200, POS_BITS'(100));
      send_word(8'd200, POS_BITS'(190));
      send_word(8'd10, POS_BITS'(10));

      // With a zero bound only the drive-back conditions take the trial.
      drain();
      c.output_bound = '0;
      load_settings(c);
      send_word(8'd100, POS_BITS'(90));
      send_word(8'd90, POS_BITS'(100));
      send_word(8'd50, POS_BITS'(50));
      send_word(8'd60, POS_BITS'(20));

      // Random segments, each under its own settings; the idling mode changes every second segment.
      for (int seg = 0; seg < 6; seg++) begin
         drain();
         case (seg)
            0: load_settings(MAX_CFG);
            2: load_settings(ZERO_CFG);
            4: load_settings(DEFAULT_CFG);
            default: load_settings(random_cfg());
         endcase
         if (seg < 2) begin
            send_idle_pct = 24;
            recv_idle_pct = 71;
         end else if (seg < 4) begin
            send_idle_pct = 71;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if (seg == 1 && n == SEG_ITEMS / 2) begin
               drain();
            end
            send_random();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("** pi_position_controller_antiwindup: PASSED **");
      end else begin
         $display("** pi_position_controller_antiwindup: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/pipc_pkg.sv
hdl/pipc_front.sv
hdl/pipc_queue.sv
hdl/pipc_back.sv
hdl/pi_position_controller_antiwindup.sv
bench/pipc_checker.sv
bench/tb_top.sv
